/* rtl/core/eucg_pkg.sv */
// Shared types and constants for the binary GCD core.
// Holds microcode opcodes, condition codes, step addresses and control word layout.
// No dependencies.
package eucg_pkg;

	localparam int STEP_W = 4;

	// datapath operations
	localparam logic [3:0] OP_NOP      = 4'd0;
	localparam logic [3:0] OP_HALVE_AB = 4'd1;
	localparam logic [3:0] OP_HALVE_A  = 4'd2;
	localparam logic [3:0] OP_HALVE_B  = 4'd3;
	localparam logic [3:0] OP_SWAP     = 4'd4;
	localparam logic [3:0] OP_SUB      = 4'd5;
	localparam logic [3:0] OP_SHL_A    = 4'd6;
	localparam logic [3:0] OP_OUT_A    = 4'd7;
	localparam logic [3:0] OP_OUT_B    = 4'd8;

	// branch conditions
	localparam logic [3:0] CND_ALWAYS    = 4'd0;
	localparam logic [3:0] CND_A_ZERO    = 4'd1;
	localparam logic [3:0] CND_B_ZERO    = 4'd2;
	localparam logic [3:0] CND_BOTH_EVEN = 4'd3;
	localparam logic [3:0] CND_A_EVEN    = 4'd4;
	localparam logic [3:0] CND_B_EVEN    = 4'd5;
	localparam logic [3:0] CND_A_GT_B    = 4'd6;
	localparam logic [3:0] CND_B_NZ      = 4'd7;
	localparam logic [3:0] CND_K_NZ      = 4'd8;

	// program addresses
	localparam logic [STEP_W-1:0] ST_CHK_A   = 4'd0;
	localparam logic [STEP_W-1:0] ST_CHK_B   = 4'd1;
	localparam logic [STEP_W-1:0] ST_COMMON  = 4'd2;
	localparam logic [STEP_W-1:0] ST_ODD_A   = 4'd3;
	localparam logic [STEP_W-1:0] ST_ODD_B   = 4'd4;
	localparam logic [STEP_W-1:0] ST_ORDER   = 4'd5;
	localparam logic [STEP_W-1:0] ST_SUB     = 4'd6;
	localparam logic [STEP_W-1:0] ST_TEST    = 4'd7;
	localparam logic [STEP_W-1:0] ST_RESCALE = 4'd8;
	localparam logic [STEP_W-1:0] ST_FIN_A   = 4'd9;
	localparam logic [STEP_W-1:0] ST_FIN_B   = 4'd10;

	typedef struct packed {
		logic [3:0]        op;
		logic [3:0]        cond;
		logic [STEP_W-1:0] target;
		logic              last;
	} ctrl_t;

	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic a_even;
		logic b_even;
		logic a_gt_b;
		logic k_nz;
	} stat_t;

endpackage

/* rtl/core/eucg_rom.sv */
// Microcode store for the binary GCD sequencer: one control word per step.
// Depends on eucg_pkg.
module eucg_rom import eucg_pkg::*; (
	input  logic [STEP_W-1:0] step,
	output ctrl_t             word
);

	always_comb begin
		case (step)
			ST_CHK_A:   word = '{op: OP_NOP,      cond: CND_A_ZERO,    target: ST_FIN_B,   last: 1'b0};
			ST_CHK_B:   word = '{op: OP_NOP,      cond: CND_B_ZERO,    target: ST_FIN_A,   last: 1'b0};
			// strip common factors of two, counted in k
			ST_COMMON:  word = '{op: OP_HALVE_AB, cond: CND_BOTH_EVEN, target: ST_COMMON,  last: 1'b0};
			ST_ODD_A:   word = '{op: OP_HALVE_A,  cond: CND_A_EVEN,    target: ST_ODD_A,   last: 1'b0};
			ST_ODD_B:   word = '{op: OP_HALVE_B,  cond: CND_B_EVEN,    target: ST_ODD_B,   last: 1'b0};
			ST_ORDER:   word = '{op: OP_SWAP,     cond: CND_A_GT_B,    target: ST_SUB,     last: 1'b0};
			ST_SUB:     word = '{op: OP_SUB,      cond: CND_ALWAYS,    target: ST_TEST,    last: 1'b0};
			ST_TEST:    word = '{op: OP_NOP,      cond: CND_B_NZ,      target: ST_ODD_B,   last: 1'b0};
			ST_RESCALE: word = '{op: OP_SHL_A,    cond: CND_K_NZ,      target: ST_RESCALE, last: 1'b0};
			ST_FIN_A:   word = '{op: OP_OUT_A,    cond: CND_ALWAYS,    target: ST_CHK_A,   last: 1'b1};
			ST_FIN_B:   word = '{op: OP_OUT_B,    cond: CND_ALWAYS,    target: ST_CHK_A,   last: 1'b1};
			default:    word = '{op: OP_NOP,      cond: CND_ALWAYS,    target: ST_CHK_A,   last: 1'b1};
		endcase
	end

endmodule

/* rtl/core/eucg_seq.sv */
// Step counter and branch logic of the GCD microsequencer.
// Depends on eucg_pkg; control words come from eucg_rom.
module eucg_seq import eucg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ctrl_t             word,
	input  stat_t             stat,
	output logic [STEP_W-1:0] step,
	output logic              busy,
	output logic              exec
);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              cond_true;

	always_comb begin
		case (word.cond)
			CND_ALWAYS:    cond_true = 1'b1;
			CND_A_ZERO:    cond_true = stat.a_zero;
			CND_B_ZERO:    cond_true = stat.b_zero;
			CND_BOTH_EVEN: cond_true = stat.a_even && stat.b_even;
			CND_A_EVEN:    cond_true = stat.a_even;
			CND_B_EVEN:    cond_true = stat.b_even;
			CND_A_GT_B:    cond_true = stat.a_gt_b;
			CND_B_NZ:      cond_true = !stat.b_zero;
			CND_K_NZ:      cond_true = stat.k_nz;
			default:       cond_true = 1'b0;
		endcase
	end

	// the op of a word runs only when its condition holds
	assign exec = busy_q && cond_true;
	assign step = step_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_CHK_A;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ST_CHK_A;
			end
		end else if (word.last) begin
			busy_q <= 1'b0;
		end else if (cond_true) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

/* rtl/core/eucg_dp.sv */
// Operand registers, shift/subtract unit and result register of the GCD core.
// Depends on eucg_pkg; driven by ops from the microsequencer.
module eucg_dp import eucg_pkg::*; #(
	parameter int W = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] first_value,
	input  logic [31:0] second_value,
	input  logic        exec,
	input  logic [3:0]  op,
	output stat_t       stat,
	output logic        done,
	output logic [31:0] divisor
);

	localparam int KW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  a_in;
	logic [W-1:0]  b_in;
	logic [31:0]   a_out;
	logic [31:0]   b_out;
	logic [31:0]   divisor_q;
	logic          done_q;

	generate
		if (W > 32) begin : g_wide
			assign a_in  = {{(W-32){1'b0}}, first_value};
			assign b_in  = {{(W-32){1'b0}}, second_value};
			assign a_out = a_q[31:0];
			assign b_out = b_q[31:0];
		end else if (W < 32) begin : g_narrow
			assign a_in  = first_value[W-1:0];
			assign b_in  = second_value[W-1:0];
			assign a_out = {{(32-W){1'b0}}, a_q};
			assign b_out = {{(32-W){1'b0}}, b_q};
		end else begin : g_same
			assign a_in  = first_value;
			assign b_in  = second_value;
			assign a_out = a_q;
			assign b_out = b_q;
		end
	endgenerate

	assign stat.a_zero = (a_q == '0);
	assign stat.b_zero = (b_q == '0);
	assign stat.a_even = !a_q[0];
	assign stat.b_even = !b_q[0];
	assign stat.a_gt_b = (a_q > b_q);
	assign stat.k_nz   = (k_q != '0);

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= a_in;
			b_q <= b_in;
			k_q <= '0;
		end else if (exec) begin
			case (op)
				OP_HALVE_AB: begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end
				OP_HALVE_A: a_q <= a_q >> 1;
				OP_HALVE_B: b_q <= b_q >> 1;
				OP_SWAP: begin
					a_q <= b_q;
					b_q <= a_q;
				end
				// a is the smaller odd value, so b - a is even and non-negative
				OP_SUB: b_q <= b_q - a_q;
				OP_SHL_A: begin
					a_q <= a_q << 1;
					k_q <= k_q - 1'b1;
				end
				OP_OUT_A: divisor_q <= a_out;
				OP_OUT_B: divisor_q <= b_out;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exec && (op == OP_OUT_A || op == OP_OUT_B);
		end
	end

	assign done    = done_q;
	assign divisor = divisor_q;

endmodule

/* rtl/core/euclid_gcd_core.sv */
// GCD core: binary GCD (shift/subtract) run by a microcoded sequencer.
// Time from accept edge to result strobe is data dependent: shortest when the first
// operand is zero, longer when only the second is, otherwise set by the loop of the
// program, which the sequencer runs at one step per cycle.
// One item at a time; a new item may be accepted in the cycle that done is high.
// The receiver cannot stall. Reset clears busy and done.
module euclid_gcd_core import eucg_pkg::*; #(
	parameter int OPERAND_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] first_value,
	input  logic [31:0] second_value,
	output logic        done,
	output logic [31:0] divisor
);

	logic [STEP_W-1:0] step;
	ctrl_t             word;
	stat_t             stat;
	logic              exec;

	eucg_rom u_rom (
		.step (step),
		.word (word)
	);

	eucg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.word   (word),
		.stat   (stat),
		.step   (step),
		.busy   (busy),
		.exec   (exec)
	);

	eucg_dp #(
		.W (OPERAND_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (start && !busy),
		.first_value  (first_value),
		.second_value (second_value),
		.exec         (exec),
		.op           (word.op),
		.stat         (stat),
		.done         (done),
		.divisor      (divisor)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in work");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still set with result shown");
`endif

endmodule
